// File: hw/rtl/pctf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctf_pkg
// Shared types and constants of the pulse counter with timestamp ring.
// ----------------------------------------------------------------------------
package pctf_pkg;

   // field widths
   localparam int COUNT_W    = 31;
   localparam int TIME_W     = 64;
   localparam int FILL_OUT_W = 10;
   localparam int OP_W       = 2;

   // entries dropped when a pulse lands in a full ring
   localparam int DISCARD_COUNT = 10;

   // request op codes
   localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // decoded command kinds handed from front to back
   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_PULSE,
      CMD_POP,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] pulse_time;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count_out;
      logic                  overflow_flag;
      logic [FILL_OUT_W-1:0] fill_level;
      logic [TIME_W-1:0]     timestamp_out;
      logic                  timestamp_valid;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [TIME_W-1:0] pulse_time;
   } cmd_type;

endpackage
`default_nettype wire

// File: hw/rtl/pulse_counter_timestamp_fifo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_counter_timestamp_fifo_core
// Metering pulse counter with a ring of pulse timestamps.
// ----------------------------------------------------------------------------
// usage
//   request channel: drive req_item and raise start; the request is taken at
//   a clock edge where start is high and busy is low. ops are pulse, pop the
//   oldest timestamp, and read-and-clear the count.
//   result channel: every request yields one result on rsp_item, marked by
//   rsp_valid for exactly one cycle; the receiver cannot stall it.
//   csr channel: csr_enable is written when csr_valid is high (csr_ready is
//   always high); write it only while no request is outstanding.
//   latency: a taken request passes through the command queue and then the
//   result register of the back end before rsp_valid rises.
//   throughput: one request per cycle; the back end finishes one command per
//   cycle with a single-port timestamp ring, so the two-entry command queue
//   never fills and busy stays low in practice.
//   reset: count, overflow flag, ring pointers and enable go to zero; the
//   ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module pulse_counter_timestamp_fifo_core #(
   parameter int RING_DEPTH = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  pctf_pkg::req_type   req_item,
   output logic                rsp_valid,
   output pctf_pkg::rsp_type   rsp_item,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire                 csr_enable
);
   import pctf_pkg::*;

   logic    req_take;
   logic    cmd_push;
   cmd_type cmd_front;
   logic    q_not_full;
   logic    q_not_empty;
   cmd_type q_head;

   assign busy     = !q_not_full;
   assign req_take = start && q_not_full;

   // front: enable register and request decode
   pctf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_enable (csr_enable),
      .req_take   (req_take),
      .req_item   (req_item),
      .cmd_push   (cmd_push),
      .cmd_out    (cmd_front)
   );

   // decoupling queue
   pctf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd_front),
      .not_full  (q_not_full),
      .pop       (q_not_empty),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   // back: counter, ring and result register
   pctf_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd_in    (q_head),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef NO_ASSERTIONS
   // a taken request is queued on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> q_not_empty)
      else $error("taken request missing from queue");

   // each executed command gives one result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      q_not_empty |=> rsp_valid)
      else $error("executed command gave no result");

   // no result without an executed command
   assert property (@(posedge clock) disable iff (reset)
      !q_not_empty |=> !rsp_valid)
      else $error("result without a command");

   // timestamp is zero unless a pop found data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.timestamp_valid) |-> (rsp_item.timestamp_out == '0))
      else $error("timestamp not zeroed");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/pctf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctf_front
// Holds the enable register and turns each request into a decoded command.
// ----------------------------------------------------------------------------
module pctf_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire                 csr_enable,
   input  wire                 req_take,
   input  pctf_pkg::req_type   req_item,
   output logic                cmd_push,
   output pctf_pkg::cmd_type   cmd_out
);
   import pctf_pkg::*;

   logic enable_ff;
   logic enable_in;

   // enable register, writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (csr_valid) begin
         enable_in = csr_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // classify request; disabled pulses and the unused code become no-ops
   always_comb begin
      cmd_out.pulse_time = req_item.pulse_time;
      case (req_item.op)
         OP_PULSE: cmd_out.kind = enable_ff ? CMD_PULSE : CMD_NOP;
         OP_POP:   cmd_out.kind = CMD_POP;
         OP_CLEAR: cmd_out.kind = CMD_CLEAR;
         default:  cmd_out.kind = CMD_NOP;
      endcase
   end

   assign cmd_push = req_take;

endmodule
`default_nettype wire

// File: hw/rtl/pctf_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctf_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module pctf_cmd_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  pctf_pkg::cmd_type   push_cmd,
   output logic                not_full,
   input  wire                 pop,
   output logic                not_empty,
   output pctf_pkg::cmd_type   head_cmd
);
   import pctf_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/pctf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctf_back
// Executes decoded commands: pulse count, timestamp ring and result register.
// ----------------------------------------------------------------------------
module pctf_back #(
   parameter int RING_DEPTH = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  pctf_pkg::cmd_type   cmd_in,
   output logic                rsp_valid,
   output pctf_pkg::rsp_type   rsp_item
);
   import pctf_pkg::*;

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = (PTR_W > FILL_OUT_W) ? PTR_W : FILL_OUT_W;

   logic [TIME_W-1:0]  ring_mem [RING_DEPTH];

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               wrapped_ff;
   logic               wrapped_in;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;

   logic               do_pulse;
   logic               do_pop;
   logic               ring_full;
   logic [PTR_W-1:0]   rd_base;
   logic [COUNT_W-1:0] count_report;
   logic [PTR_W-1:0]   fill_now;
   logic [PTR_W-1:0]   fill_next;
   logic [FILL_W-1:0]  fill_wide;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_wrapped_ff;
   logic [FILL_OUT_W-1:0] rsp_fill_ff;
   logic               rsp_ts_valid_ff;
   logic [TIME_W-1:0]  rd_data_ff;

   // pointer advance by a small step, modulo ring depth
   function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p,
                                                     input logic [PTR_W:0]   n);
      logic [PTR_W:0] sum;
      begin
         sum = {1'b0, p} + n;
         if (sum >= (PTR_W+1)'(RING_DEPTH)) begin
            sum = sum - (PTR_W+1)'(RING_DEPTH);
         end
         ring_advance = sum[PTR_W-1:0];
      end
   endfunction

   // entries held between read and write pointers
   function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] diff;
      begin
         if (wp >= rp) begin
            diff = {1'b0, wp} - {1'b0, rp};
         end else begin
            diff = (PTR_W+1)'(RING_DEPTH) - {1'b0, rp} + {1'b0, wp};
         end
         ring_fill = diff[PTR_W-1:0];
      end
   endfunction

   // command decode and state update
   always_comb begin
      do_pulse     = cmd_valid && (cmd_in.kind == CMD_PULSE);
      fill_now     = ring_fill(wr_ptr_ff, rd_ptr_ff);
      ring_full    = (fill_now == PTR_W'(RING_DEPTH - 1));
      do_pop       = cmd_valid && (cmd_in.kind == CMD_POP) && (wr_ptr_ff != rd_ptr_ff);

      count_in     = count_ff;
      wrapped_in   = wrapped_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_base      = rd_ptr_ff;

      if (do_pulse) begin
         if (count_ff == '1) begin
            count_in   = '0;
            wrapped_in = 1'b1;
         end else begin
            count_in   = count_ff + COUNT_W'(1);
         end
         if (ring_full) begin
            rd_base = ring_advance(rd_ptr_ff, (PTR_W+1)'(DISCARD_COUNT));
         end
         wr_ptr_in = ring_advance(wr_ptr_ff, (PTR_W+1)'(1));
      end

      count_report = count_in;
      rd_ptr_in    = rd_base;

      if (do_pop) begin
         rd_ptr_in = ring_advance(rd_ptr_ff, (PTR_W+1)'(1));
      end else if (cmd_valid && (cmd_in.kind == CMD_CLEAR)) begin
         count_in = '0;
      end

      fill_next = ring_fill(wr_ptr_in, rd_ptr_in);
      fill_wide = FILL_W'(fill_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wrapped_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         wrapped_ff <= wrapped_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
      end
   end

   // timestamp ring, one write and one registered read
   always_ff @(posedge clock) begin
      if (do_pulse) begin
         ring_mem[wr_ptr_ff] <= cmd_in.pulse_time;
      end
      if (do_pop) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         rsp_count_ff    <= count_report;
         rsp_wrapped_ff  <= wrapped_in;
         rsp_fill_ff     <= fill_wide[FILL_OUT_W-1:0];
         rsp_ts_valid_ff <= do_pop;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_item.count_out       = rsp_count_ff;
   assign rsp_item.overflow_flag   = rsp_wrapped_ff;
   assign rsp_item.fill_level      = rsp_fill_ff;
   assign rsp_item.timestamp_out   = rsp_ts_valid_ff ? rd_data_ff : '0;
   assign rsp_item.timestamp_valid = rsp_ts_valid_ff;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pulse counter with timestamp ring against a built-in predictor.
// A short table of directed requests covers reset state, disabled pulses,
// empty pops, clears and the unused op. Random phases then fill the ring past
// full so that the ten-entry discard repeats, drain it to empty, and run with
// counting disabled. Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import pctf_pkg::*;

   localparam int RING_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int N_DIRECTED  = 23;

   localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         cfg_value;
      req_type      req;
      logic         typed;
      rsp_type      status;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_enable;

   // predictor state
   logic               meter_enable;
   logic [COUNT_W-1:0] pulse_total;
   logic               count_wrapped;
   int                 ring_wr;
   int                 ring_rd;
   logic [TIME_W-1:0]  ring_mem [RING_DEPTH];
   int                 ring_discards;
   int                 empty_pops;

   rsp_type pending_status [$];
   int      mismatch_count;
   int      cycle_count;
   logic    gaps_on;

   // directed requests; typed status only where it is obvious
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQ, 1'b0, '{OP_PULSE, ~64'd0}, 1'b1, '{31'd0, 1'b0, 10'd0, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b1, '{31'd0, 1'b0, 10'd0, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_CLEAR, 64'd0}, 1'b1, '{31'd0, 1'b0, 10'd0, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_UNUSED, ~64'd0}, 1'b1, '{31'd0, 1'b0, 10'd0, 64'd0, 1'b0}},
      '{ROW_CFG, 1'b1, '0, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_PULSE, 64'd0}, 1'b1, '{31'd1, 1'b0, 10'd1, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_PULSE, ~64'd0}, 1'b1, '{31'd2, 1'b0, 10'd2, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_PULSE, 64'h8000_0000_0000_0001}, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_UNUSED, 64'h0123_4567_89ab_cdef}, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_POP, ~64'd0}, 1'b1, '{31'd3, 1'b0, 10'd2, 64'd0, 1'b1}},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b1, '{31'd3, 1'b0, 10'd1, ~64'd0, 1'b1}},
      '{ROW_REQ, 1'b0, '{OP_CLEAR, ~64'd0}, 1'b1, '{31'd3, 1'b0, 10'd1, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_CLEAR, 64'd0}, 1'b1, '{31'd0, 1'b0, 10'd1, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b1, '{31'd0, 1'b0, 10'd0, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_PULSE, 64'h5555_5555_5555_5555}, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_PULSE, 64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
      '{ROW_CFG, 1'b0, '0, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_PULSE, 64'd1}, 1'b1, '{31'd2, 1'b0, 10'd2, 64'd0, 1'b0}},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b0, '0},
      '{ROW_CFG, 1'b1, '0, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b0, '0},
      '{ROW_REQ, 1'b0, '{OP_POP, 64'd0}, 1'b0, '0}
   };

   pulse_counter_timestamp_fifo_core #(
      .RING_DEPTH (RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_enable (csr_enable)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // timestamps held in the ring
   function automatic int ring_level();
      return (ring_wr - ring_rd + RING_DEPTH) % RING_DEPTH;
   endfunction

   // status for one request, advancing the predicted counter and ring
   function automatic rsp_type predict_status(input req_type r);
      rsp_type o;
      o = '0;
      if (r.op == OP_PULSE && meter_enable) begin
         // count wraps at the 31-bit maximum and latches the overflow flag
         if (pulse_total == COUNT_MAX) begin
            pulse_total   = '0;
            count_wrapped = 1'b1;
         end else begin
            pulse_total = pulse_total + 1'b1;
         end
         // full ring drops its ten oldest timestamps before the write
         if (ring_level() >= RING_DEPTH - 1) begin
            ring_rd = (ring_rd + DISCARD_COUNT) % RING_DEPTH;
            ring_discards++;
         end
         ring_mem[ring_wr] = r.pulse_time;
         ring_wr = (ring_wr + 1) % RING_DEPTH;
      end
      o.count_out = pulse_total;
      if (r.op == OP_POP && ring_level() != 0) begin
         o.timestamp_out   = ring_mem[ring_rd];
         o.timestamp_valid = 1'b1;
         ring_rd = (ring_rd + 1) % RING_DEPTH;
      end else if (r.op == OP_POP) begin
         empty_pops++;
      end else if (r.op == OP_CLEAR) begin
         pulse_total = '0;
      end
      o.overflow_flag = count_wrapped;
      o.fill_level    = FILL_OUT_W'(ring_level());
      return o;
   endfunction

   // issue one request and record its expected status once taken
   task automatic send_request(input req_type r, input logic typed, input rsp_type typed_status);
      rsp_type predicted;
      while (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = predict_status(r);
      pending_status.push_back(typed ? typed_status : predicted);
   endtask

   // random request with the given op mix in percent, unused op takes the rest
   task automatic send_random(input int pulse_pct, input int pop_pct, input int clear_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(99);
      if (roll < pulse_pct)
         r.op = OP_PULSE;
      else if (roll < pulse_pct + pop_pct)
         r.op = OP_POP;
      else if (roll < pulse_pct + pop_pct + clear_pct)
         r.op = OP_CLEAR;
      else
         r.op = OP_UNUSED;
      r.pulse_time = {$urandom, $urandom};
      send_request(r, 1'b0, '0);
   endtask

   // enable write, only once all results are back
   task automatic write_enable(input logic value);
      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      csr_valid  <= 1'b1;
      csr_enable <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      meter_enable = value;
   endtask

   // result checker, sampled mid-cycle
   always @(negedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: count %h ovf %b fill %h ts %h tv %b",
                  rsp_item.count_out, rsp_item.overflow_flag, rsp_item.fill_level,
                  rsp_item.timestamp_out, rsp_item.timestamp_valid);
         end else begin
            want = pending_status.pop_front();
            if (rsp_item.count_out !== want.count_out ||
                  rsp_item.overflow_flag !== want.overflow_flag ||
                  rsp_item.fill_level !== want.fill_level ||
                  rsp_item.timestamp_out !== want.timestamp_out ||
                  rsp_item.timestamp_valid !== want.timestamp_valid) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch at %0t: expected count %h ovf %b fill %h ts %h tv %b",
                     $realtime, want.count_out, want.overflow_flag, want.fill_level,
                     want.timestamp_out, want.timestamp_valid);
                  $display("                 actual   count %h ovf %b fill %h ts %h tv %b",
                     rsp_item.count_out, rsp_item.overflow_flag, rsp_item.fill_level,
                     rsp_item.timestamp_out, rsp_item.timestamp_valid);
               end
            end
         end
      end
   end

   // stimulus
   initial begin : drive_requests
      int n;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_valid      = 1'b0;
      csr_enable     = 1'b0;
      meter_enable   = 1'b0;
      pulse_total    = '0;
      count_wrapped  = 1'b0;
      ring_wr        = 0;
      ring_rd        = 0;
      ring_discards  = 0;
      empty_pops     = 0;
      mismatch_count = 0;
      gaps_on        = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CFG)
            write_enable(directed_rows[i].cfg_value);
         else
            send_request(directed_rows[i].req, directed_rows[i].typed,
               directed_rows[i].status);
      end

      // mixed traffic
      for (n = 0; n < 250; n++) send_random(50, 30, 10);

      // back-to-back pulses until the ring has overrun several times
      gaps_on = 1'b0;
      n = 0;
      while (ring_discards < 6 && n < 2500) begin
         send_random(97, 1, 1);
         n++;
      end
      gaps_on = 1'b1;

      // drain to empty and keep popping past it
      n = 0;
      while ((ring_level() != 0 || empty_pops < 8) && n < 2500) begin
         send_random(5, 90, 3);
         n++;
      end

      // counting disabled
      write_enable(1'b0);
      for (n = 0; n < 100; n++) send_random(50, 30, 10);

      // counting enabled again
      write_enable(1'b1);
      for (n = 0; n < 250; n++) send_random(55, 30, 8);

      // wait for the last results
      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/pctf_pkg.sv
hw/rtl/pctf_front.sv
hw/rtl/pctf_cmd_queue.sv
hw/rtl/pctf_back.sv
hw/rtl/pulse_counter_timestamp_fifo_core.sv
tb/sv/testbench.sv
